// ----- rtl/stal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stal_pkg: shared types and constants of the sorted table address lookup
// Item and result layouts, operation codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package stal_pkg;

    // default configuration of the table
    parameter int TABLE_DEPTH_DEF  = 1024;
    parameter int HANDLER_BITS_DEF = 16;

    // fixed field widths
    parameter int FUNC_W     = 1;
    parameter int INDEX_W    = 10;
    parameter int ADDR_W     = 32;
    parameter int HANDLER_W  = 16;
    parameter int POSITION_W = 11;
    parameter int COUNT_W    = 11;

    // configuration port
    parameter int PADDR_W = 3;
    parameter int PDATA_W = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

    // register index, taken from the word address bit of paddr
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [INDEX_W-1:0]   entry_index;
        logic [ADDR_W-1:0]    guest_address;
        logic [HANDLER_W-1:0] handler_in;
    } t_stal_in;

    typedef struct packed {
        logic                  found;
        logic [HANDLER_W-1:0]  handler_out;
        logic [POSITION_W-1:0] position;
    } t_stal_out;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_stal_state;

endpackage

// ----- rtl/stal_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stal_search: table storage and binary search sequencer
// Holds the address and handler memories, takes writes and runs
// a lower-bound search with one memory probe per cycle.
// ----------------------------------------------------------------------------
module stal_search
    import stal_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int HANDLER_BITS = HANDLER_BITS_DEF,
    parameter int CW           = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_stal_in      i_item,
    input  logic [CW-1:0] i_limit,
    output logic          o_busy,
    output logic          o_done,
    output t_stal_out     o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [ADDR_W-1:0]       r_addr_mem [TABLE_DEPTH];
    logic [HANDLER_BITS-1:0] r_hdl_mem  [TABLE_DEPTH];

    t_stal_state             r_state, n_state;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_mid, n_mid;
    logic [ADDR_W-1:0]       r_target, n_target;
    logic                    r_eq, n_eq;
    logic [HANDLER_BITS-1:0] r_eq_hdl, n_eq_hdl;
    logic [ADDR_W-1:0]       r_rd_addr;
    logic [HANDLER_BITS-1:0] r_rd_hdl;
    logic                    r_done, n_done;
    t_stal_out               r_result, n_result;

    logic                    below;
    logic [CW-1:0]           step_lo, step_hi, step_mid;
    logic                    step_more;
    logic                    step_eq;
    logic [HANDLER_BITS-1:0] step_hdl;
    logic                    wr_en;
    logic                    lookup_go;

    assign lookup_go = i_start && (i_item.func == FUNC_LOOKUP);
    assign wr_en     = i_start && (i_item.func == FUNC_WRITE)
                       && (32'(i_item.entry_index) < 32'(TABLE_DEPTH));

    // one probe: narrow the window on the word read back
    assign below     = r_rd_addr < r_target;
    assign step_lo   = below ? r_mid + CW'(1) : r_lo;
    assign step_hi   = below ? r_hi : r_mid;
    assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
    assign step_more = step_lo < step_hi;
    // the last probed entry not below the target sits at the final lower bound
    assign step_eq   = below ? r_eq : (r_rd_addr == r_target);
    assign step_hdl  = below ? r_eq_hdl : r_rd_hdl;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_addr_mem[AW'(i_item.entry_index)] <= i_item.guest_address;
            r_hdl_mem[AW'(i_item.entry_index)]  <= HANDLER_BITS'(i_item.handler_in);
        end
        r_rd_addr <= r_addr_mem[AW'(n_mid)];
        r_rd_hdl  <= r_hdl_mem[AW'(n_mid)];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (lookup_go && (i_limit != '0)) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!step_more) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_target = r_target;
        n_eq     = r_eq;
        n_eq_hdl = r_eq_hdl;
        n_done   = 1'b0;
        n_result = r_result;
        o_busy   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_lo     = '0;
                n_hi     = i_limit;
                n_mid    = i_limit >> 1;
                n_target = i_item.guest_address;
                n_eq     = 1'b0;
                // empty window: report position zero at once
                if (lookup_go && (i_limit == '0)) begin
                    n_done               = 1'b1;
                    n_result.found       = 1'b0;
                    n_result.handler_out = '0;
                    n_result.position    = '0;
                end
            end
            ST_PROBE: begin
                o_busy   = 1'b1;
                n_lo     = step_lo;
                n_hi     = step_hi;
                n_mid    = step_mid;
                n_eq     = step_eq;
                n_eq_hdl = step_hdl;
                if (!step_more) begin
                    n_done               = 1'b1;
                    n_result.found       = step_eq;
                    n_result.handler_out = step_eq ? HANDLER_W'(step_hdl) : '0;
                    n_result.position    = POSITION_W'(step_lo);
                end
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_eq     <= n_eq;
        r_eq_hdl <= n_eq_hdl;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/sorted_table_address_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_address_lookup_core: sorted address table with lower-bound search
// A write word stores one entry with no result. A lookup probes one entry
// per cycle: P = ceil(log2(limit+1)) probes at most (11 for 1024 entries).
// The result strobe is registered from the last probe and busy drops with it,
// so the next word is taken at the edge that ends the strobe. An empty search
// reports from the idle state without raising busy.
// The single read port of the table memory sets the probe rate.
// Synchronous reset clears entry_count and the sequencer; the table is not
// cleared. The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_table_address_lookup_core
    import stal_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_stal_in           i_item,
    output logic               o_done,
    output t_stal_out          o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] r_entry_count;
    logic [CW-1:0]      limit;
    logic               accept;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ENTRY_COUNT) begin
            prdata = PDATA_W'(r_entry_count);
        end
    end

    // saturate the count to the table depth
    assign limit = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(r_entry_count);

    assign accept = start && !busy;

    stal_search #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HANDLER_BITS (HANDLER_BITS),
        .CW           (CW)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_item   (i_item),
        .i_limit  (limit),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for sorted_table_address_lookup_core
// Loads sorted address tables with write words, sets entry_count over the APB
// port and checks every lookup result against a lower-bound search kept in
// the testbench. Commands come in random bursts with random gaps if gaps_on.
// ----------------------------------------------------------------------------
module tb_top;
    import stal_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_stal_in           i_item;
    logic               o_done;
    t_stal_out          o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // shadow of the table and the count register
    logic [ADDR_W-1:0]    addr_mem    [DEPTH];
    logic [HANDLER_W-1:0] handler_mem [DEPTH];
    logic [COUNT_W-1:0]   entry_count_q;
    t_stal_out            lookup_expect_q [$];

    int errors;
    int burst_left;
    bit gaps_on;

    sorted_table_address_lookup_core i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_stal_out search_lower_bound(input logic [ADDR_W-1:0] target);
        int        lo;
        int        hi;
        int        mid;
        int        limit;
        t_stal_out r;
        limit = (entry_count_q > DEPTH) ? DEPTH : int'(entry_count_q);
        lo = 0;
        hi = limit;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (addr_mem[INDEX_W'(mid)] < target) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        r = '0;
        r.position = lo[POSITION_W-1:0];
        if (lo < limit && addr_mem[INDEX_W'(lo)] == target) begin
            r.found       = 1'b1;
            r.handler_out = handler_mem[INDEX_W'(lo)];
        end
        return r;
    endfunction

    function automatic logic [HANDLER_W-1:0] pick_handler();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return HANDLER_W'($urandom);
    endfunction

    task automatic send_word(input t_stal_in w);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 7);
            burst_left = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        // hold start high: a following word keeps it up without a dip
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        if (w.func == FUNC_LOOKUP) begin
            lookup_expect_q.push_back(search_lower_bound(w.guest_address));
        end else begin
            addr_mem[w.entry_index]    = w.guest_address;
            handler_mem[w.entry_index] = w.handler_in;
        end
    endtask

    task automatic write_entry(input int slot, input logic [ADDR_W-1:0] a,
                               input logic [HANDLER_W-1:0] h);
        t_stal_in w;
        w.func          = FUNC_WRITE;
        w.entry_index   = slot[INDEX_W-1:0];
        w.guest_address = a;
        w.handler_in    = h;
        send_word(w);
    endtask

    task automatic lookup_addr(input logic [ADDR_W-1:0] a);
        t_stal_in w;
        w.func          = FUNC_LOOKUP;
        w.entry_index   = INDEX_W'($urandom);
        w.guest_address = a;
        w.handler_in    = HANDLER_W'($urandom);
        send_word(w);
    endtask

    // drop start, let every lookup report and give the last write time to land
    task automatic drain_results();
        start <= 1'b0;
        while (lookup_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [COUNT_W-1:0] c);
        logic [PDATA_W-1:0] d;
        d = $urandom;
        d[COUNT_W-1:0] = c;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_COUNT;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        entry_count_q = c;
    endtask

    // fill slots 0..n-1 with ascending addresses, at times with duplicates and extremes
    task automatic load_sorted_table(input int n);
        logic [ADDR_W-1:0] sorted_q [$];
        int                i;
        int                slot;
        bit                descend;
        for (i = 0; i < n; i++) sorted_q.push_back($urandom);
        if ($urandom_range(0, 2) == 0) sorted_q[0] = '0;
        if ($urandom_range(0, 2) == 0) sorted_q[n-1] = '1;
        sorted_q.sort();
        for (i = 1; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) sorted_q[i] = sorted_q[i-1];
        end
        descend = 1'($urandom_range(0, 1));
        for (i = 0; i < n; i++) begin
            slot = descend ? n - 1 - i : i;
            write_entry(slot, sorted_q[slot], pick_handler());
            // stray words beyond the searched range
            if (n < DEPTH && $urandom_range(0, 9) == 0) begin
                write_entry($urandom_range(n, DEPTH - 1), $urandom, pick_handler());
            end
        end
    endtask

    task automatic run_lookups(input int n_lookups);
        int                limit;
        int                i;
        int                k;
        int                sel;
        longint unsigned   lo_a;
        longint unsigned   hi_a;
        longint unsigned   r;
        logic [ADDR_W-1:0] t;
        limit = (entry_count_q > DEPTH) ? DEPTH : int'(entry_count_q);
        lookup_addr('1);
        lookup_addr('0);
        for (i = 0; i < n_lookups; i++) begin
            // rewrite a slot in place, keeping it between its neighbours
            if (limit > 0 && $urandom_range(0, 4) == 0) begin
                k    = $urandom_range(0, limit - 1);
                lo_a = (k > 0) ? longint'(addr_mem[INDEX_W'(k - 1)]) : 0;
                hi_a = (k < limit - 1) ? longint'(addr_mem[INDEX_W'(k + 1)])
                                       : 64'hFFFF_FFFF;
                r    = 64'($urandom);
                write_entry(k, ADDR_W'(lo_a + r % (hi_a - lo_a + 1)), pick_handler());
            end
            sel = $urandom_range(0, 9);
            if (limit > 0 && sel < 7) begin
                t = addr_mem[INDEX_W'($urandom_range(0, limit - 1))];
                if (sel == 5) t = t + 1'b1;
                if (sel == 6) t = t - 1'b1;
            end else begin
                t = $urandom;
            end
            lookup_addr(t);
        end
    endtask

    task automatic test_empty_table();
        set_entry_count(0);
        lookup_addr(32'h0000_0000);
        lookup_addr(32'hFFFF_FFFF);
        lookup_addr(32'h8000_0000);
    endtask

    task automatic test_directed_edges();
        write_entry(0, 32'h0000_0010, 16'h0000);  // match with a zero handler
        write_entry(1, 32'h0000_0020, 16'hFFFF);
        write_entry(2, 32'h0000_0020, 16'h1234);  // duplicate: lower bound takes slot 1
        write_entry(3, 32'hFFFF_FFFF, 16'h5555);
        write_entry(DEPTH - 1, 32'h0000_0000, 16'hAAAA);
        set_entry_count(4);
        lookup_addr(32'h0000_0000);
        lookup_addr(32'h0000_0010);
        lookup_addr(32'h0000_0015);
        lookup_addr(32'h0000_0020);
        lookup_addr(32'h0000_0021);
        lookup_addr(32'hFFFF_FFFE);
        lookup_addr(32'hFFFF_FFFF);
        // target above every searched entry: position equals the count
        set_entry_count(1);
        lookup_addr(32'hFFFF_FFFF);
        lookup_addr(32'h0000_0010);
        write_entry(0, 32'h0000_0000, 16'h0001);
        lookup_addr(32'h0000_0000);
    endtask

    task automatic test_random_small_tables();
        int counts [7];
        int i;
        counts = '{1, 2, 3, 7, 0, 0, 0};
        for (i = 4; i < 7; i++) counts[i] = $urandom_range(4, 64);
        for (i = 0; i < 7; i++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            load_sorted_table(counts[i]);
            set_entry_count(counts[i]);
            run_lookups(30);
        end
    endtask

    // counts at and above the depth saturate; shorter prefixes come last
    task automatic test_full_table();
        int counts [5];
        int i;
        counts = '{DEPTH, 2047, 0, DEPTH - 1, 0};
        counts[2] = $urandom_range(DEPTH + 1, 2046);
        counts[4] = $urandom_range(64, DEPTH - 2);
        gaps_on = 1'b1;
        load_sorted_table(DEPTH);
        for (i = 0; i < 5; i++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            set_entry_count(counts[i]);
            run_lookups(60);
        end
    endtask

    always @(posedge i_clk) begin
        t_stal_out exp_r;
        if (i_rst_n && o_done) begin
            if (lookup_expect_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: expected none actual %h",
                         $time, o_result);
            end else begin
                exp_r = lookup_expect_q.pop_front();
                if (o_result.found !== exp_r.found) begin
                    errors++;
                    $display("%0t: found: expected %0d actual %0d",
                             $time, exp_r.found, o_result.found);
                end
                if (o_result.handler_out !== exp_r.handler_out) begin
                    errors++;
                    $display("%0t: handler_out: expected %h actual %h",
                             $time, exp_r.handler_out, o_result.handler_out);
                end
                if (o_result.position !== exp_r.position) begin
                    errors++;
                    $display("%0t: position: expected %0d actual %0d",
                             $time, exp_r.position, o_result.position);
                end
            end
        end
    end

    initial begin
        errors        = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        entry_count_q = '0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_directed_edges();
        test_random_small_tables();
        test_full_table();
        drain_results();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
